### src/grlp_pkg.sv
// Shared types, widths, gas table and codes for the gas ratio power-law unit.
package grlp_pkg;

    localparam int RES_W   = 15;
    localparam int QUO_W   = 31;
    localparam int RAT_W   = 22;
    localparam int EXPO_W  = 20;
    localparam int COEF_W  = 26;
    localparam int L_W     = 22;
    localparam int PPM_W   = 24;
    localparam int ST_W    = 2;
    localparam int DIV_BPS = 4;
    localparam int DIV_ST  = (QUO_W + DIV_BPS - 1) / DIV_BPS;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_BASE   = 2'd1;
    localparam logic [ST_W-1:0] ST_READ_FAIL = 2'd2;
    localparam logic [ST_W-1:0] ST_NAN       = 2'd3;

    localparam logic [1:0] CH0 = 2'd0;
    localparam logic [1:0] CH1 = 2'd1;
    localparam logic [1:0] CH2 = 2'd2;

    localparam logic [1:0] CFG_BASE0  = 2'd0;
    localparam logic [1:0] CFG_BASE1  = 2'd1;
    localparam logic [1:0] CFG_BASE2  = 2'd2;
    localparam logic [1:0] CFG_LOADED = 2'd3;

    localparam logic [PPM_W-1:0] PPM_MAX = '1;

    typedef struct packed {
        logic [2:0]      gas;
        logic [ST_W-1:0] status;
        logic            force_hi;
    } t_meta;

    typedef struct packed {
        logic [1:0]               chan;
        logic [RAT_W-1:0]         lo;
        logic [RAT_W-1:0]         hi;
        logic signed [EXPO_W-1:0] expo;
        logic [COEF_W-1:0]        coef;
    } t_gas_row;

    // CO, NO2, NH3, C3H8, C4H10, CH4, H2, ethanol
    localparam t_gas_row GAS_ROWS [8] = '{
        '{CH1, 22'd655,   22'd196608,  -20'sd77267,  26'd287375},
        '{CH2, 22'd4588,  22'd2621440,  20'sd65995,  26'd9560},
        '{CH0, 22'd2621,  22'd52429,   -20'sd109445, 26'd44582},
        '{CH0, 22'd15073, 22'd52429,   -20'sd165020, 26'd37366268},
        '{CH0, 22'd9830,  22'd42598,   -20'sd140116, 26'd26090340},
        '{CH1, 22'd32768, 22'd45875,   -20'sd285934, 26'd41350398},
        '{CH1, 22'd2621,  22'd52429,   -20'sd117965, 26'd47841},
        '{CH1, 22'd2621,  22'd72090,   -20'sd101712, 26'd106299}
    };

endpackage

### src/grlp_div.sv
// Pipelined restoring divider: reading * 2^16 / baseline, up to 4 quotient bits per stage.
module grlp_div (
    input  logic                          i_clk,
    input  logic [grlp_pkg::DIV_ST-1:0]   i_adv,
    input  logic [grlp_pkg::RES_W-1:0]    i_num,
    input  logic [grlp_pkg::RES_W-1:0]    i_den,
    input  grlp_pkg::t_meta               i_meta,
    output logic [grlp_pkg::QUO_W-1:0]    o_quo,
    output grlp_pkg::t_meta               o_meta
);
    import grlp_pkg::*;

    typedef struct packed {
        logic [RES_W-1:0] rem;
        logic [QUO_W-1:0] num;
        logic [QUO_W-1:0] quo;
        logic [RES_W-1:0] den;
        t_meta            meta;
    } t_div_st;

    t_div_st r_st [DIV_ST];
    t_div_st n_st [DIV_ST];
    t_div_st w_init;

    assign w_init = '{rem: '0, num: {i_num, {(QUO_W-RES_W){1'b0}}}, quo: '0,
                      den: i_den, meta: i_meta};

    always_comb begin
        t_div_st v;
        logic [RES_W:0] t;
        for (int k = 0; k < DIV_ST; k++) begin
            v = (k == 0) ? w_init : r_st[(k == 0) ? 0 : k-1];
            for (int b = 0; b < DIV_BPS; b++) begin
                if (k*DIV_BPS + b < QUO_W) begin
                    t = {v.rem, v.num[QUO_W-1]};
                    v.num = {v.num[QUO_W-2:0], 1'b0};
                    if (t >= {1'b0, v.den}) begin
                        v.rem = RES_W'(t - {1'b0, v.den});
                        v.quo = {v.quo[QUO_W-2:0], 1'b1};
                    end else begin
                        v.rem = t[RES_W-1:0];
                        v.quo = {v.quo[QUO_W-2:0], 1'b0};
                    end
                end
            end
            n_st[k] = v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_ST; k++) begin
            if (i_adv[k]) begin
                r_st[k] <= n_st[k];
            end
        end
    end

    assign o_quo  = r_st[DIV_ST-1].quo;
    assign o_meta = r_st[DIV_ST-1].meta;

endmodule

### src/grlp_log.sv
// Ratio clamp, leading-one normalize and log2 table lookup (signed Q16 result).
module grlp_log #(
    parameter int LOG_TABLE_ADDR_BITS = 8
) (
    input  logic                              i_clk,
    input  logic [2:0]                        i_adv,
    input  logic [grlp_pkg::QUO_W-1:0]        i_quo,
    input  grlp_pkg::t_meta                   i_meta,
    output logic signed [grlp_pkg::L_W-1:0]   o_l,
    output grlp_pkg::t_meta                   o_meta
);
    import grlp_pkg::*;

    localparam int A     = LOG_TABLE_ADDR_BITS;
    localparam int LOG_N = 1 << A;
    localparam int P_BW  = $clog2(RAT_W);

    typedef logic [15:0] t_ltab [LOG_N];

    function automatic logic [15:0] f_log_frac(int unsigned idx);
        longint unsigned x;
        logic [15:0] fr;
        x  = (64'd1 << 30) | (longint'(idx) << (30 - A));
        fr = '0;
        for (int k = 0; k < 16; k++) begin
            x  = (x * x) >> 30;
            fr = {fr[14:0], 1'b0};
            if (x >= (64'd2 << 30)) begin
                fr[0] = 1'b1;
                x = x >> 1;
            end
        end
        return fr;
    endfunction

    function automatic t_ltab f_build();
        t_ltab tb;
        for (int i = 0; i < LOG_N; i++) begin
            tb[i] = f_log_frac(i);
        end
        return tb;
    endfunction

    localparam t_ltab LOG_TAB = f_build();

    t_gas_row          w_row;
    logic [QUO_W-1:0]  w_sel;
    logic [RAT_W-1:0]  n_rat;
    logic [RAT_W-1:0]  r_rat;
    t_meta             r_meta1;

    logic [P_BW-1:0]   n_p;
    logic [RAT_W-1:0]  w_norm;
    logic [P_BW-1:0]   r_p;
    logic [A-1:0]      r_idx;
    t_meta             r_meta2;

    logic signed [5:0] w_pm16;
    logic signed [L_W-1:0] r_l;
    t_meta             r_meta3;

    assign w_row = GAS_ROWS[i_meta.gas];
    assign w_sel = i_meta.force_hi ? QUO_W'(w_row.hi) : i_quo;

    always_comb begin
        if (w_sel < QUO_W'(w_row.lo)) begin
            n_rat = w_row.lo;
        end else if (w_sel > QUO_W'(w_row.hi)) begin
            n_rat = w_row.hi;
        end else begin
            n_rat = w_sel[RAT_W-1:0];
        end
    end

    always_comb begin
        n_p = '0;
        for (int i = 0; i < RAT_W; i++) begin
            if (r_rat[i]) begin
                n_p = P_BW'(i);
            end
        end
    end

    assign w_norm = r_rat << (P_BW'(RAT_W-1) - n_p);
    assign w_pm16 = $signed({1'b0, r_p}) - 6'sd16;

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_rat   <= n_rat;
            r_meta1 <= i_meta;
        end
        if (i_adv[1]) begin
            r_p     <= n_p;
            r_idx   <= w_norm[RAT_W-2 -: A];
            r_meta2 <= r_meta1;
        end
        if (i_adv[2]) begin
            r_l     <= {w_pm16, LOG_TAB[r_idx]};
            r_meta3 <= r_meta2;
        end
    end

    assign o_l    = r_l;
    assign o_meta = r_meta3;

endmodule

### src/grlp_exp.sv
// Exponent multiply, exp2 table, coefficient multiply and scale/saturate output stage.
module grlp_exp #(
    parameter int LOG_TABLE_ADDR_BITS = 8
) (
    input  logic                              i_clk,
    input  logic [3:0]                        i_adv,
    input  logic signed [grlp_pkg::L_W-1:0]   i_l,
    input  grlp_pkg::t_meta                   i_meta,
    output logic [grlp_pkg::PPM_W-1:0]        o_ppm,
    output logic [grlp_pkg::ST_W-1:0]         o_status
);
    import grlp_pkg::*;

    localparam int A     = LOG_TABLE_ADDR_BITS;
    localparam int EXP_N = 1 << A;
    localparam int P_W   = 31;
    localparam int EL_W  = EXPO_W + L_W + 1;
    localparam int Y_W   = EL_W - 16;
    localparam int N_W   = Y_W - 16;
    localparam int PR_W  = COEF_W + P_W;

    typedef logic [P_W-1:0] t_etab [EXP_N];

    function automatic longint unsigned f_isqrt(longint unsigned v_in);
        longint unsigned v;
        longint unsigned res;
        longint unsigned bt;
        v   = v_in;
        res = 0;
        bt  = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (v >= res + bt) begin
                v   = v - (res + bt);
                res = (res >> 1) + bt;
            end else begin
                res = res >> 1;
            end
            bt = bt >> 2;
        end
        return res;
    endfunction

    function automatic logic [P_W-1:0] f_exp_val(int unsigned j);
        longint unsigned c;
        longint unsigned p;
        c = f_isqrt(64'd1 << 61);
        p = 64'd1 << 30;
        for (int k = 1; k <= A; k++) begin
            if (((j >> (A - k)) & 1) != 0) begin
                p = (p * c) >> 30;
            end
            c = f_isqrt(c << 30);
        end
        return p[P_W-1:0];
    endfunction

    function automatic t_etab f_build();
        t_etab tb;
        for (int i = 0; i < EXP_N; i++) begin
            tb[i] = f_exp_val(i);
        end
        return tb;
    endfunction

    localparam t_etab EXP_TAB = f_build();

    logic signed [EXPO_W-1:0] w_expo;
    logic signed [EL_W-1:0]   w_el;
    logic signed [Y_W-1:0]    r_y;
    t_meta                    r_meta1;

    logic signed [N_W-1:0]    r_n2;
    logic [P_W-1:0]           r_pw;
    t_meta                    r_meta2;

    logic [PR_W-1:0]          r_prod;
    logic signed [N_W-1:0]    r_n3;
    t_meta                    r_meta3;

    logic signed [N_W:0]      w_s;
    logic [PR_W-1:0]          w_sh;
    logic [PPM_W-1:0]         n_ppm;
    logic [PPM_W-1:0]         r_ppm;
    logic [ST_W-1:0]          r_status;

    assign w_expo = GAS_ROWS[i_meta.gas].expo;
    assign w_el   = w_expo * i_l + EL_W'(32768);

    assign w_s  = (N_W+1)'(38) - r_n3;
    assign w_sh = r_prod >> w_s[5:0];

    always_comb begin
        if (r_meta3.status != ST_OK) begin
            n_ppm = '0;
        end else if (w_s <= 0) begin
            n_ppm = PPM_MAX;
        end else if (w_s >= 64) begin
            n_ppm = '0;
        end else if (w_sh > PR_W'(PPM_MAX)) begin
            n_ppm = PPM_MAX;
        end else begin
            n_ppm = w_sh[PPM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv[0]) begin
            r_y     <= w_el[EL_W-1:16];
            r_meta1 <= i_meta;
        end
        if (i_adv[1]) begin
            r_n2    <= r_y[Y_W-1:16];
            r_pw    <= EXP_TAB[r_y[15 -: A]];
            r_meta2 <= r_meta1;
        end
        if (i_adv[2]) begin
            r_prod  <= PR_W'(GAS_ROWS[r_meta2.gas].coef) * PR_W'(r_pw);
            r_n3    <= r_n2;
            r_meta3 <= r_meta2;
        end
        if (i_adv[3]) begin
            r_ppm    <= n_ppm;
            r_status <= r_meta3.status;
        end
    end

    assign o_ppm    = r_ppm;
    assign o_status = r_status;

endmodule

### src/gas_ratio_power_law_ppm_unit.sv
// Top level: gas ppm from resistance ratio by power law, fully pipelined.
//
//  channel  | signals                                       | direction
//  ---------+-----------------------------------------------+----------
//  request  | i_in_valid, o_in_stall, i_action, i_resist_*, | in
//           | i_reading_ok                                  |
//  result   | o_out_valid, i_out_stall, o_ppm_value,        | out
//           | o_status_code                                 |
//  config   | i_cfg_valid, o_cfg_ready, i_cfg_index,        | in
//           | i_cfg_wdata                                   |
//
//  One request per cycle unless stalled; each request passes through
//  capture, 8 divider stages of up to 4 quotient bits, 3 log, 4 exp stages.
//  Each stage loads when empty or when the stage after it moves, so bubbles
//  close up under output stall. Synchronous active-low reset clears the
//  valid bits and the baseline registers.
module gas_ratio_power_law_ppm_unit #(
    parameter int LOG_TABLE_ADDR_BITS = 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [2:0]                   i_action,
    input  logic [grlp_pkg::RES_W-1:0]   i_resist_ch0,
    input  logic [grlp_pkg::RES_W-1:0]   i_resist_ch1,
    input  logic [grlp_pkg::RES_W-1:0]   i_resist_ch2,
    input  logic                         i_reading_ok,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [grlp_pkg::PPM_W-1:0]   o_ppm_value,
    output logic [grlp_pkg::ST_W-1:0]    o_status_code,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [1:0]                   i_cfg_index,
    input  logic [grlp_pkg::RES_W-1:0]   i_cfg_wdata
);
    import grlp_pkg::*;

    localparam int NST    = DIV_ST + 8;
    localparam int LOG_S0 = DIV_ST + 1;
    localparam int EXP_S0 = DIV_ST + 4;

    logic [RES_W-1:0] r_base0;
    logic [RES_W-1:0] r_base1;
    logic [RES_W-1:0] r_base2;
    logic             r_loaded;

    logic [NST-1:0]   r_vld;
    logic [NST-1:0]   n_vld;
    logic [NST-1:0]   w_en;

    t_gas_row         w_row;
    logic [RES_W-1:0] w_read;
    logic [RES_W-1:0] w_base;
    t_meta            w_meta;

    logic [RES_W-1:0] r_s0_num;
    logic [RES_W-1:0] r_s0_den;
    t_meta            r_s0_meta;

    logic [QUO_W-1:0] w_quo;
    t_meta            w_div_meta;
    logic signed [L_W-1:0] w_l;
    t_meta            w_log_meta;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base0  <= '0;
            r_base1  <= '0;
            r_base2  <= '0;
            r_loaded <= 1'b0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BASE0:  r_base0  <= i_cfg_wdata;
                CFG_BASE1:  r_base1  <= i_cfg_wdata;
                CFG_BASE2:  r_base2  <= i_cfg_wdata;
                CFG_LOADED: r_loaded <= i_cfg_wdata[0];
            endcase
        end
    end

    always_comb begin
        w_en[NST-1] = !r_vld[NST-1] || !i_out_stall;
        for (int k = NST-2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < NST; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign w_row = GAS_ROWS[i_action];

    always_comb begin
        unique case (w_row.chan)
            CH0: begin
                w_read = i_resist_ch0;
                w_base = r_base0;
            end
            CH1: begin
                w_read = i_resist_ch1;
                w_base = r_base1;
            end
            default: begin
                w_read = i_resist_ch2;
                w_base = r_base2;
            end
        endcase
    end

    always_comb begin
        w_meta.gas      = i_action;
        w_meta.force_hi = (w_base == '0);
        priority if (!r_loaded) begin
            w_meta.status = ST_NO_BASE;
        end else if (!i_reading_ok) begin
            w_meta.status = ST_READ_FAIL;
        end else if (w_base == '0 && w_read == '0) begin
            w_meta.status = ST_NAN;
        end else begin
            w_meta.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_num  <= w_read;
            r_s0_den  <= w_base;
            r_s0_meta <= w_meta;
        end
    end

    grlp_div u_div (
        .i_clk  (i_clk),
        .i_adv  (w_en[DIV_ST:1]),
        .i_num  (r_s0_num),
        .i_den  (r_s0_den),
        .i_meta (r_s0_meta),
        .o_quo  (w_quo),
        .o_meta (w_div_meta)
    );

    grlp_log #(
        .LOG_TABLE_ADDR_BITS (LOG_TABLE_ADDR_BITS)
    ) u_log (
        .i_clk  (i_clk),
        .i_adv  (w_en[LOG_S0+2:LOG_S0]),
        .i_quo  (w_quo),
        .i_meta (w_div_meta),
        .o_l    (w_l),
        .o_meta (w_log_meta)
    );

    grlp_exp #(
        .LOG_TABLE_ADDR_BITS (LOG_TABLE_ADDR_BITS)
    ) u_exp (
        .i_clk    (i_clk),
        .i_adv    (w_en[EXP_S0+3:EXP_S0]),
        .i_l      (w_l),
        .i_meta   (w_log_meta),
        .o_ppm    (o_ppm_value),
        .o_status (o_status_code)
    );

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[NST-1];

endmodule

### src/grlp_chk.sv
// Port-level checker for the gas ratio power-law unit, bound to the top level.
module grlp_chk (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_in_stall,
    input logic                         o_out_valid,
    input logic                         i_out_stall,
    input logic [grlp_pkg::PPM_W-1:0]   o_ppm_value,
    input logic [grlp_pkg::ST_W-1:0]    o_status_code
);
    import grlp_pkg::*;

    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_ppm_value) && $stable(o_status_code))
        else $error("stalled result changed");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status_code != ST_OK |-> o_ppm_value == '0)
        else $error("nonzero ppm with error status");

    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("request stalled while output drains");

endmodule

bind gas_ratio_power_law_ppm_unit grlp_chk u_grlp_chk (.*);
